>>> rtl/psv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psv_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 32;
  localparam int NLEN_W    = 11;
  localparam int SEED_W    = 31;
  localparam int NOISE_W   = 32;
  localparam int PROD_W    = GAIN_W + SAMPLE_W;

  // Park-Miller multiplier, loop filter coefficient and reset gain.
  localparam logic signed [15:0] PM_MULT    = 16'sd16807;
  localparam logic signed [15:0] LOOP_COEF  = 16'sd32686;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 32'd52428;
  localparam logic [SEED_W-1:0]  SEED_RESET = 31'd1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GEN  = 6'b000010,
    S_PUT  = 6'b000100,
    S_FILT = 6'b001000,
    S_MUL  = 6'b010000,
    S_PUSH = 6'b100000
  } state_t;

  // One step of the Park-Miller generator, split into 16-bit halves.
  function automatic logic [NOISE_W-1:0] next_noise(input logic [NOISE_W-1:0] lo);
    logic signed [31:0] hi;
    logic [30:0]        lo_mul;
    logic [32:0]        sum;
    logic [31:0]        wrapped;
    hi      = 32'(PM_MULT) * 32'($signed(lo[31:16]));
    lo_mul  = 31'(PM_MULT[14:0]) * 31'(lo[15:0]);
    sum     = {2'b00, lo_mul} + {2'b00, hi[14:0], 16'h0000} + {16'h0000, hi[31:15]};
    wrapped = sum[31:0];
    next_noise = {1'b0, wrapped[30:0]} + {31'h0, wrapped[31]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/psv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module psv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/plucked_string_voice_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Karplus-Strong string voice. A pluck request (in_op = 1) sets the loop
// length, capped at MAX_LEN, and fills that many entries of the delay RAM with
// Park-Miller noise scaled by in_strike_level; it gives no result and keeps the
// input stalled while it fills, each entry taking a generator step in S_GEN
// and a scaled write in S_PUT. A tick request (in_op = 0) reads the current
// entry, averages it with the previous old entry, writes it back and returns
// one sample scaled by the 16.16 gain in cfg_data and saturated to 16 bits. A
// tick that plays goes through the RAM read and loop filter multiply in S_FILT
// and the gain multiply in S_MUL before S_PUSH; a silent one goes straight to
// S_PUSH. Before the first pluck, or after a pluck of length zero, ticks
// return 0. A finished sample waits in the output register while the next
// request is taken. The gain register is always ready; the user must ensure
// it is written only while the voice is idle, as the block does not check.
module plucked_string_voice_top
  import psv_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_op,
  input  wire logic [NLEN_W-1:0]          in_note_length,
  input  wire logic [15:0]                in_strike_level,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_sample_out,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic signed [GAIN_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);

  state_t                      state_r, state_nxt;
  logic signed [GAIN_W-1:0]    gain_r;
  logic [SEED_W-1:0]           seed_r, seed_nxt;
  logic [NOISE_W-1:0]          lo_r, lo_nxt;
  logic [15:0]                 mag_r, mag_nxt;
  logic [LEN_W-1:0]            loop_len_r, loop_len_nxt;
  logic [ADDR_W-1:0]           read_idx_r, read_idx_nxt;
  logic [ADDR_W-1:0]           fill_idx_r, fill_idx_nxt;
  logic signed [SAMPLE_W-1:0]  prior_r, prior_nxt;
  logic                        playing_r, playing_nxt;
  logic signed [SAMPLE_W-1:0]  filt_r, filt_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;

  logic                        in_fire;
  logic [LEN_W-1:0]            len_cap;
  logic [ADDR_W-1:0]           tick_idx;
  logic [LEN_W-1:0]            idx_inc;
  logic                        tick_live;
  logic                        fill_last;
  logic signed [32:0]          noise_prod;
  logic signed [SAMPLE_W-1:0]  noise_sample;
  logic signed [SAMPLE_W:0]    pair_sum;
  logic signed [32:0]          loop_acc;
  logic signed [SAMPLE_W-1:0]  filt_val;
  logic signed [31:0]          gained;
  logic signed [SAMPLE_W-1:0]  gained_sat;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [SAMPLE_W-1:0]         mem_wdata;
  logic [SAMPLE_W-1:0]         mem_rdata;

  assign in_stall       = (state_r != S_IDLE);
  assign in_fire        = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign len_cap = (32'(in_note_length) > MAX_LEN) ? LEN_W'(MAX_LEN)
                                                    : LEN_W'(in_note_length);

  assign tick_idx  = (LEN_W'(read_idx_r) < loop_len_r) ? read_idx_r : '0;
  assign idx_inc   = LEN_W'(tick_idx) + LEN_W'(1);
  assign tick_live = playing_r && (loop_len_r != '0);
  assign fill_last = (LEN_W'(fill_idx_r) == loop_len_r - LEN_W'(1));

  // Noise entry: the low half of the generator word as a signed fraction.
  assign noise_prod   = 33'($signed({1'b0, mag_r})) * 33'($signed(lo_r[15:0]));
  assign noise_sample = noise_prod[31:16];

  // Both loop taps share the same coefficient, so add first and multiply once.
  assign pair_sum = (SAMPLE_W+1)'($signed(mem_rdata)) + (SAMPLE_W+1)'(prior_r);
  assign loop_acc = 33'(pair_sum) * 33'(LOOP_COEF);
  assign filt_val = loop_acc[31:16];

  assign gained = prod_r[PROD_W-1:16];
  always_comb begin
    if (gained > 32'(SAMPLE_MAX)) begin
      gained_sat = SAMPLE_MAX;
    end else if (gained < 32'(SAMPLE_MIN)) begin
      gained_sat = SAMPLE_MIN;
    end else begin
      gained_sat = gained[SAMPLE_W-1:0];
    end
  end

  assign mem_we    = (state_r == S_PUT) || (state_r == S_FILT);
  assign mem_waddr = (state_r == S_PUT) ? fill_idx_r : tick_idx;
  assign mem_wdata = (state_r == S_PUT) ? noise_sample : filt_val;

  psv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_LEN)
  ) u_delay_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (tick_idx),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = seed_r;
    lo_nxt         = lo_r;
    mag_nxt        = mag_r;
    loop_len_nxt   = loop_len_r;
    read_idx_nxt   = read_idx_r;
    fill_idx_nxt   = fill_idx_r;
    prior_nxt      = prior_r;
    playing_nxt    = playing_r;
    filt_nxt       = filt_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op) begin
            loop_len_nxt = len_cap;
            read_idx_nxt = '0;
            fill_idx_nxt = '0;
            prior_nxt    = '0;
            playing_nxt  = 1'b1;
            mag_nxt      = in_strike_level;
            lo_nxt       = {1'b0, seed_r};
            state_nxt    = (len_cap == '0) ? S_IDLE : S_GEN;
          end else if (tick_live) begin
            // The RAM read of the current entry is issued on this edge.
            state_nxt = S_FILT;
          end else begin
            prod_nxt  = '0;
            state_nxt = S_PUSH;
          end
        end
      end
      S_GEN: begin
        lo_nxt    = next_noise(lo_r);
        state_nxt = S_PUT;
      end
      S_PUT: begin
        fill_idx_nxt = fill_idx_r + ADDR_W'(1);
        if (fill_last) begin
          prior_nxt = noise_sample;
          seed_nxt  = lo_r[SEED_W-1:0];
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_GEN;
        end
      end
      S_FILT: begin
        filt_nxt     = filt_val;
        prior_nxt    = $signed(mem_rdata);
        read_idx_nxt = (idx_inc >= loop_len_r) ? '0 : ADDR_W'(idx_inc);
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(gain_r) * PROD_W'(filt_r);
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = gained_sat;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      seed_r      <= SEED_RESET;
      loop_len_r  <= '0;
      read_idx_r  <= '0;
      fill_idx_r  <= '0;
      prior_r     <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      loop_len_r  <= loop_len_nxt;
      read_idx_r  <= read_idx_nxt;
      fill_idx_r  <= fill_idx_nxt;
      prior_r     <= prior_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    mag_r        <= mag_nxt;
    filt_r       <= filt_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
  end

`ifndef SYNTHESIS
  a_read_idx_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (loop_len_r != '0) |-> (LEN_W'(read_idx_r) < loop_len_r))
    else $error("read index outside the loop length");

  a_fill_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (LEN_W'(fill_idx_r) < loop_len_r))
    else $error("fill address outside the loop length");

  a_tick_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_op && tick_live) |=> ##2 (state_r == S_PUSH))
    else $error("tick did not reach the output stage in time");

  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_sample_r)))
    else $error("waiting sample was overwritten");
`endif

endmodule
`default_nettype wire

>>> tb/plucked_string_voice_top_test.sv
`timescale 1ns / 1ps
module plucked_string_voice_top_test;
  import psv_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam bit OP_TICK = 1'b0;
  localparam bit OP_PLUCK = 1'b1;
  localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 32'sd65536;
  localparam logic signed [GAIN_W-1:0] GAIN_TOP = 32'sh7FFF0000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

  // Tracks the string state and keeps the samples that ticks should return.
  class voice_scoreboard;
    logic signed [SAMPLE_W-1:0] delay_line [MAX_LEN];
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] prior;
    logic signed [GAIN_W-1:0] gain;
    logic [SEED_W-1:0] seed;
    int unsigned loop_len;
    int unsigned rd_idx;
    bit plucked;
    int errors;

    function new();
      foreach (delay_line[i]) delay_line[i] = '0;
      prior = '0;
      gain = GAIN_RESET;
      seed = SEED_RESET;
      loop_len = 0;
      rd_idx = 0;
      plucked = 1'b0;
      errors = 0;
    endfunction

    // Park-Miller step done in 16-bit halves, with the end-around carry.
    static function logic [31:0] park_miller(logic [31:0] lo);
      logic signed [31:0] hi;
      logic [31:0] acc;
      hi = int'(PM_MULT) * int'($signed(lo[31:16]));
      acc = {16'h0, PM_MULT} * {16'h0, lo[15:0]};
      acc = acc + {1'b0, hi[14:0], 16'h0000};
      acc = acc + ($unsigned(hi) >> 15);
      return {1'b0, acc[30:0]} + {31'h0, acc[31]};
    endfunction

    function void note_request(bit op, logic [NLEN_W-1:0] len, logic [15:0] strike);
      logic [31:0] lo;
      logic signed [SAMPLE_W-1:0] cur;
      logic signed [SAMPLE_W-1:0] filt;
      logic signed [SAMPLE_W-1:0] sample;
      longint acc;
      longint scaled;
      int unsigned n;
      int unsigned idx;
      if (op == OP_PLUCK) begin
        n = (len > MAX_LEN) ? MAX_LEN : len;
        lo = {1'b0, seed};
        for (int i = 0; i < n; i++) begin
          lo = park_miller(lo);
          acc = longint'(strike) * longint'($signed(lo[15:0]));
          delay_line[i] = 16'(acc >>> 16);
        end
        seed = lo[30:0];
        loop_len = n;
        rd_idx = 0;
        prior = (n > 0) ? delay_line[n-1] : '0;
        plucked = 1'b1;
      end else begin
        sample = '0;
        if (plucked && loop_len != 0) begin
          idx = (rd_idx < loop_len) ? rd_idx : 0;
          cur = delay_line[idx];
          acc = (longint'(cur) + longint'(prior)) * LOOP_COEF;
          filt = 16'(acc >>> 16);
          delay_line[idx] = filt;
          prior = cur;
          idx++;
          rd_idx = (idx >= loop_len) ? 0 : idx;
          if (gain == 0) begin
            sample = '0;
          end else if (gain == UNITY_GAIN) begin
            sample = filt;
          end else begin
            scaled = (longint'(gain) * longint'(filt)) >>> 16;
            if (scaled > 32767) sample = SAMPLE_MAX;
            else if (scaled < -32768) sample = SAMPLE_MIN;
            else sample = 16'(scaled);
          end
        end
        expected_samples.push_back(sample);
      end
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: sample %0d returned with none expected", $time, actual);
        errors++;
      end else begin
        want = expected_samples.pop_front();
        if (want !== actual) begin
          $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [NLEN_W-1:0] in_note_length = '0;
  logic [15:0] in_strike_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [GAIN_W-1:0] cfg_data = '0;

  voice_scoreboard sb;
  int burst_left = 0;
  int samples_taken = 0;
  int hold_left = 0;
  int style_left = 0;
  bit long_hold_done = 1'b0;
  stall_style_t stall_style = STALL_NONE;

  plucked_string_voice_top #(.MAX_LEN(MAX_LEN)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_note_length(in_note_length),
    .in_strike_level(in_strike_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Offers one request and returns once the block has taken it. Valid stays
  // high between requests of a burst and only drops for a gap.
  task automatic offer(bit op, logic [NLEN_W-1:0] len, logic [15:0] strike);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_note_length <= len;
    in_strike_level <= strike;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, len, strike);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      sb.check_sample(out_sample_out);
      samples_taken++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ((!long_hold_done && samples_taken >= 100) || $urandom_range(0, 3999) == 0) begin
      // A long hold lets the block back up until it stalls its input.
      long_hold_done = 1'b1;
      hold_left = $urandom_range(200, 500);
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(32, 400);
      end
      style_left--;
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    logic signed [GAIN_W-1:0] gain_plan [$];
    logic [NLEN_W-1:0] len;
    logic [15:0] strike;
    int pick;
    int done;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks before any pluck are silent.
    offer(OP_TICK, 11'd0, 16'd0);
    offer(OP_TICK, 11'd2047, 16'hFFFF);
    // A pluck of length zero leaves the voice silent.
    offer(OP_PLUCK, 11'd0, 16'hFFFF);
    repeat (2) offer(OP_TICK, 11'(($urandom)), 16'($urandom));
    // A one-sample loop keeps reading the same entry.
    offer(OP_PLUCK, 11'd1, 16'hFFFF);
    repeat (3) offer(OP_TICK, 11'(($urandom)), 16'($urandom));
    // A note longer than the store is capped at the store depth.
    offer(OP_PLUCK, 11'd2047, 16'hFFFF);
    repeat (3) offer(OP_TICK, 11'd0, 16'd0);
    offer(OP_PLUCK, 11'd1024, 16'h8000);
    repeat (2) offer(OP_TICK, 11'd0, 16'd0);
    offer(OP_PLUCK, 11'd5, 16'd0);
    repeat (2) offer(OP_TICK, 11'd0, 16'd0);
    offer(OP_PLUCK, 11'd2, 16'd1);
    repeat (2) offer(OP_TICK, 11'd0, 16'd0);

    gain_plan.push_back(UNITY_GAIN);
    gain_plan.push_back('0);
    gain_plan.push_back(GAIN_TOP);
    gain_plan.push_back(-GAIN_TOP);
    gain_plan.push_back(GAIN_W'($urandom_range(0, 32'hFFFE0000) - 32'h7FFF0000));
    gain_plan.push_back(-GAIN_W'($urandom_range(1, 200000)));
    gain_plan.push_back(32'sd1);
    gain_plan.push_back(-UNITY_GAIN);
    gain_plan.push_back(GAIN_RESET);

    foreach (gain_plan[k]) begin
      // The gain only changes once the voice has gone quiet; a trailing
      // pluck gives no sample, so allow for a full-length fill as well.
      in_valid <= 1'b0;
      @(posedge clk);
      while (sb.expected_samples.size() != 0) @(posedge clk);
      repeat (2 * MAX_LEN + 8) @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_data <= gain_plan[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cfg_valid <= 1'b0;
      sb.gain = gain_plan[k];

      done = 0;
      while (done < 88) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) len = '0;
        else if (pick < 5) len = 11'($urandom_range(1024, 2047));
        else if (pick < 12) len = 11'($urandom_range(65, 1023));
        else len = 11'($urandom_range(1, 64));
        pick = $urandom_range(0, 19);
        if (pick < 2) strike = 16'hFFFF;
        else if (pick < 3) strike = 16'($urandom_range(0, 15));
        else strike = 16'($urandom);
        offer(OP_PLUCK, len, strike);
        done++;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 30)) begin
          offer(OP_TICK, 11'($urandom), 16'($urandom));
          done++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_samples.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.expected_samples.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, sb.expected_samples.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
